// File: hw/rtl/eop_pkg.sv
package eop_pkg;

    localparam int NUM_FLOORS = 4;
    localparam int FLOOR_W    = 2;
    localparam int IDX_W      = $clog2(NUM_FLOORS);
    localparam int CMP_W      = (IDX_W > FLOOR_W) ? IDX_W : FLOOR_W;
    localparam int LIGHTS_W   = 12;

    // opcodes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SERVED = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // order kinds
    localparam logic [1:0] KIND_CAB     = 2'd0;
    localparam logic [1:0] KIND_HALL_UP = 2'd1;
    localparam logic [1:0] KIND_HALL_DN = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // pending bits of the floor under scan
    typedef struct packed {
        logic cab;
        logic hall_up;
        logic hall_dn;
    } floor_bits_t;

    // accumulated scan results, relative to the car's floor
    typedef struct packed {
        logic any_lo;
        logic any_hi;
        logic any_at;
        logic cab_at;
        logic up_at;
        logic dn_at;
    } scan_flags_t;

endpackage

// File: hw/rtl/elevator_order_planner.sv
// Channel | Handshake          | Payload
// --------+--------------------+-----------------------------------------------
// in      | in_valid/in_ready  | opcode, order_floor, order_kind, current_floor,
//         |                    | at_floor, above_floor, travel_direction
// out     | out_valid/out_ready| should_move, should_stop, next_direction,
//         |                    | order_lights
//
// One request occupies the block from the idle state that accepts it, through
// ST_UPDATE, which updates the pending bits, ST_SCAN, which steps each floor
// through the shared compare unit, to ST_FINISH, which loads the result; out_valid
// rises when ST_FINISH loads the output register.
// in_ready is high only in idle; a new request may be taken while the previous
// result still waits in the output register.
// A stalled output holds the sequencer in its last step until the register frees.
// Reset clears all pending orders and the control state.
module elevator_order_planner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [1:0]  order_floor,
    input  logic [1:0]  order_kind,
    input  logic [1:0]  current_floor,
    input  logic        at_floor,
    input  logic        above_floor,
    input  logic        travel_direction,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        should_move,
    output logic        should_stop,
    output logic        next_direction,
    output logic [11:0] order_lights
);
    import eop_pkg::*;

    state_t state_reg;
    state_t state_next;

    // latched request
    logic [1:0]         op_reg;
    logic [1:0]         ofl_reg;
    logic [1:0]         kind_reg;
    logic [FLOOR_W-1:0] cur_reg;
    logic               at_reg;
    logic               above_reg;
    logic               down_reg;

    // pending orders, bit i = floor i
    logic [NUM_FLOORS-1:0] cab_reg,  cab_next;
    logic [NUM_FLOORS-1:0] up_reg,   up_next;
    logic [NUM_FLOORS-1:0] dn_reg,   dn_next;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             last_idx;

    logic        in_acc;
    logic        out_free;
    logic        scan_clear;
    logic        scan_step;
    logic        load_out;
    floor_bits_t cur_bits;
    scan_flags_t flags;

    logic        stop_c;
    logic        ndown_c;
    logic [3*NUM_FLOORS+LIGHTS_W-1:0] lights_ext;

    logic        out_valid_reg;
    logic        move_reg;
    logic        stop_reg;
    logic        ndir_reg;
    logic [LIGHTS_W-1:0] lights_reg;

    assign in_acc   = in_valid & in_ready;
    assign out_free = ~out_valid_reg | out_ready;
    assign last_idx = idx_reg == IDX_W'(NUM_FLOORS - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (last_idx)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        scan_clear = 1'b0;
        scan_step  = 1'b0;
        load_out   = 1'b0;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_UPDATE:
            begin
                scan_clear = 1'b1;
                idx_next   = '0;
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                idx_next  = idx_reg + 1'b1;
            end
            ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // order update: per-floor decode of add and clear
    always_comb
    begin
        cab_next = cab_reg;
        up_next  = up_reg;
        dn_next  = dn_reg;
        if (state_reg == ST_UPDATE)
        begin
            for (int i = 0; i < NUM_FLOORS; i++)
            begin
                if (op_reg == OP_ADD && CMP_W'(ofl_reg) == CMP_W'(i))
                begin
                    case (kind_reg)
                        KIND_CAB:     cab_next[i] = 1'b1;
                        KIND_HALL_UP: up_next[i]  = 1'b1;
                        KIND_HALL_DN: dn_next[i]  = 1'b1;
                        default:      cab_next[i] = cab_reg[i];
                    endcase
                end
                else if (op_reg == OP_SERVED && CMP_W'(cur_reg) == CMP_W'(i))
                begin
                    cab_next[i] = 1'b0;
                    up_next[i]  = 1'b0;
                    dn_next[i]  = 1'b0;
                end
                else if (op_reg == OP_FLUSH)
                begin
                    cab_next[i] = 1'b0;
                    up_next[i]  = 1'b0;
                    dn_next[i]  = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        cur_bits.cab     = cab_reg[idx_reg];
        cur_bits.hall_up = up_reg[idx_reg];
        cur_bits.hall_dn = dn_reg[idx_reg];
    end

    eop_scan_unit u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .step      (scan_step),
        .idx       (idx_reg),
        .car_floor (cur_reg),
        .bits      (cur_bits),
        .flags     (flags)
    );

    // stop and scan-rule direction from the accumulated flags
    always_comb
    begin
        if (!at_reg)
        begin
            stop_c = 1'b1;
        end
        else
        begin
            stop_c = flags.cab_at
                   | (down_reg ? flags.dn_at : flags.up_at)
                   | (down_reg ? ~flags.any_lo : ~flags.any_hi);
        end

        if (at_reg || above_reg)
        begin
            // above the floor going down, the floor itself counts as below
            if (!down_reg)
            begin
                ndown_c = ~flags.any_hi;
            end
            else
            begin
                ndown_c = flags.any_lo | (~at_reg & flags.any_at);
            end
        end
        else
        begin
            // below the floor going up, the floor itself counts as above
            if (!down_reg)
            begin
                ndown_c = ~(flags.any_hi | flags.any_at);
            end
            else
            begin
                ndown_c = flags.any_lo;
            end
        end

        lights_ext = {{LIGHTS_W{1'b0}}, dn_reg, up_reg, cab_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cab_reg       <= '0;
            up_reg        <= '0;
            dn_reg        <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cab_reg   <= cab_next;
            up_reg    <= up_next;
            dn_reg    <= dn_next;
            idx_reg   <= idx_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg    <= opcode;
            ofl_reg   <= order_floor;
            kind_reg  <= order_kind;
            cur_reg   <= current_floor;
            at_reg    <= at_floor;
            above_reg <= above_floor;
            down_reg  <= travel_direction;
        end
        if (load_out)
        begin
            move_reg   <= |{cab_reg, up_reg, dn_reg};
            stop_reg   <= stop_c;
            ndir_reg   <= ndown_c;
            lights_reg <= lights_ext[LIGHTS_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign should_move    = move_reg;
    assign should_stop    = stop_reg;
    assign next_direction = ndir_reg;
    assign order_lights   = lights_reg;

endmodule

// File: hw/rtl/eop_scan_unit.sv
module eop_scan_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      step,
    input  logic [eop_pkg::IDX_W-1:0] idx,
    input  logic [eop_pkg::FLOOR_W-1:0] car_floor,
    input  eop_pkg::floor_bits_t      bits,
    output eop_pkg::scan_flags_t      flags
);
    import eop_pkg::*;

    scan_flags_t flags_reg;
    scan_flags_t flags_next;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] flr_ext;
    logic             any_bit;
    logic             lt;
    logic             eq;

    // one magnitude compare per floor, shared across the scan
    always_comb
    begin
        idx_ext = CMP_W'(idx);
        flr_ext = CMP_W'(car_floor);
        lt      = idx_ext < flr_ext;
        eq      = idx_ext == flr_ext;
        any_bit = bits.cab | bits.hall_up | bits.hall_dn;

        flags_next = flags_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else if (step)
        begin
            if (lt)
            begin
                flags_next.any_lo = flags_reg.any_lo | any_bit;
            end
            else if (eq)
            begin
                flags_next.any_at = flags_reg.any_at | any_bit;
                flags_next.cab_at = flags_reg.cab_at | bits.cab;
                flags_next.up_at  = flags_reg.up_at  | bits.hall_up;
                flags_next.dn_at  = flags_reg.dn_at  | bits.hall_dn;
            end
            else
            begin
                flags_next.any_hi = flags_reg.any_hi | any_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule
